[design/utf8_name_encoding_classifier_assert.svh]
// Assertion macros shared by the name encoding classifier.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef UTF8_NAME_ENCODING_CLASSIFIER_ASSERT_SVH
`define UTF8_NAME_ENCODING_CLASSIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTF8NC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UTF8NC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/utf8nc_pkg.sv]
// Types and constants of the UTF-8 name encoding classifier.
// Used by the step logic and the top level; depends on nothing.
package utf8nc_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] CpMinTwo   = 21'h00_0080;
  localparam logic [CpW-1:0] CpMinThree = 21'h00_0800;
  localparam logic [CpW-1:0] CpMinFour  = 21'h01_0000;
  localparam logic [CpW-1:0] CpSurLo    = 21'h00_D800;
  localparam logic [CpW-1:0] CpSurHi    = 21'h00_DFFF;
  localparam logic [CpW-1:0] CpMax      = 21'h10_FFFF;

  localparam logic [2:0] LeadTwo   = 3'b110;
  localparam logic [3:0] LeadThree = 4'b1110;
  localparam logic [4:0] LeadFour  = 5'b11110;
  localparam logic [1:0] ContTag   = 2'b10;

  localparam logic [1:0] ExtraOne   = 2'd1;
  localparam logic [1:0] ExtraTwo   = 2'd2;
  localparam logic [1:0] ExtraThree = 2'd3;

  typedef enum logic [1:0] {
    ENC_ASCII = 2'd0,
    ENC_UTF8  = 2'd1,
    ENC_CP437 = 2'd2
  } enc_class_e;

  typedef struct packed {
    logic [1:0]     cont_left;
    logic [CpW-1:0] cp_accum;
    logic [1:0]     seq_extra;
    logic           saw_high;
    logic           failed;
  } scan_state_t;

  typedef struct packed {
    logic       valid;
    enc_class_e enc_class;
    logic       utf8_valid;
  } scan_result_t;

endpackage

[design/utf8nc_if.sv]
// Valid/ready request channels of the name encoding classifier.
// Byte requests in, class requests out; no dependencies.
interface utf8nc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       last_byte;
  logic       empty_name;

  modport source (output valid, output name_byte, output last_byte, output empty_name,
                  input ready);
  modport sink   (input valid, input name_byte, input last_byte, input empty_name,
                  output ready);
endinterface

interface utf8nc_class_if;
  logic       valid;
  logic       ready;
  logic [1:0] encoding_class;
  logic       utf8_valid;

  modport source (output valid, output encoding_class, output utf8_valid, input ready);
  modport sink   (input valid, input encoding_class, input utf8_valid, output ready);
endinterface

[design/utf8_name_encoding_classifier.sv]
// Top level of the UTF-8 name encoding classifier: input register, scan state, result register.
// Depends on utf8nc_pkg, utf8nc_if, utf8nc_step and the assertion macro header.
//
//   channel    | dir | carries                               | request ends when
//   byte_req_i | in  | name_byte, last_byte, empty_name      | valid and ready high at a clock edge
//   class_req_o| out | encoding_class, utf8_valid            | valid and ready high at a clock edge
//
// One byte is taken every cycle unless the input register stalls; the scan state updates as
// the byte leaves it; a final byte or empty-name request also loads the result register.
// The input register stalls only while it holds a final byte or an empty-name request and the
// result register is full and its class request is not taken in that cycle.
// Reset clears the scan state and both valid flags; no warm-up follows reset.
module utf8_name_encoding_classifier (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  utf8nc_byte_if.sink           byte_req_i,
  utf8nc_class_if.source        class_req_o
);
  import utf8nc_pkg::*;

  `include "utf8_name_encoding_classifier_assert.svh"

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_last_q;
  logic         in_empty_q;
  scan_state_t  state_q;
  scan_state_t  state_d;
  scan_result_t step_res;
  logic         out_valid_q;
  enc_class_e   out_class_q;
  logic         out_utf8_q;
  logic         out_free;
  logic         advance;
  logic         in_take;

  utf8nc_step u_step (
    .cur_i        (state_q),
    .name_byte_i  (in_byte_q),
    .last_byte_i  (in_last_q),
    .empty_name_i (in_empty_q),
    .nxt_o        (state_d),
    .res_o        (step_res)
  );

  assign out_free = !out_valid_q || class_req_o.ready;
  assign advance  = in_valid_q && (!step_res.valid || out_free);
  assign in_take  = byte_req_i.valid && byte_req_i.ready;

  assign byte_req_i.ready          = !in_valid_q || advance;
  assign class_req_o.valid         = out_valid_q;
  assign class_req_o.encoding_class = out_class_q;
  assign class_req_o.utf8_valid    = out_utf8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (byte_req_i.ready) begin
        in_valid_q <= byte_req_i.valid;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && step_res.valid) begin
        out_valid_q <= 1'b1;
      end else if (class_req_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q  <= byte_req_i.name_byte;
      in_last_q  <= byte_req_i.last_byte;
      in_empty_q <= byte_req_i.empty_name;
    end
    if (advance && step_res.valid) begin
      out_class_q <= step_res.enc_class;
      out_utf8_q  <= step_res.utf8_valid;
    end
  end

  `UTF8NC_ASSERT_NOW(a_valid_not_cp437, out_valid_q && out_utf8_q,
    out_class_q != ENC_CP437, "A valid UTF-8 name is reported as CP437.")
  `UTF8NC_ASSERT_NOW(a_invalid_is_cp437, out_valid_q && !out_utf8_q,
    out_class_q == ENC_CP437, "An invalid name is not reported as CP437.")
  `UTF8NC_ASSERT_NOW(a_fail_no_pending, state_q.failed,
    state_q.cont_left == 2'd0, "A failed scan still expects continuation bytes.")
  `UTF8NC_ASSERT_NEXT(a_clear_after_result, advance && step_res.valid,
    state_q == '0, "The scan state is not cleared after a result.")
  `UTF8NC_ASSERT_NOW(a_hold_when_full, in_valid_q && step_res.valid && !out_free,
    !advance && !byte_req_i.ready, "A result advanced into a full result register.")

endmodule

[design/utf8nc_step.sv]
// Next-state and result logic for one name byte of the UTF-8 scan.
// Purely combinational; depends on utf8nc_pkg.
module utf8nc_step (
  input  utf8nc_pkg::scan_state_t  cur_i,
  input  logic [7:0]               name_byte_i,
  input  logic                     last_byte_i,
  input  logic                     empty_name_i,
  output utf8nc_pkg::scan_state_t  nxt_o,
  output utf8nc_pkg::scan_result_t res_o
);
  import utf8nc_pkg::*;

  scan_state_t    st;
  logic [CpW-1:0] cp_new;
  logic [1:0]     left_new;
  logic           overlong;
  logic           bad_range;

  always_comb begin
    st        = cur_i;
    cp_new    = {cur_i.cp_accum[CpW-7:0], name_byte_i[5:0]};
    left_new  = cur_i.cont_left - 2'd1;
    overlong  = ((cur_i.seq_extra == ExtraOne)   && (cp_new < CpMinTwo))   ||
                ((cur_i.seq_extra == ExtraTwo)   && (cp_new < CpMinThree)) ||
                ((cur_i.seq_extra == ExtraThree) && (cp_new < CpMinFour));
    bad_range = ((cp_new >= CpSurLo) && (cp_new <= CpSurHi)) || (cp_new > CpMax);
    res_o     = '{valid: 1'b0, enc_class: ENC_ASCII, utf8_valid: 1'b1};

    if (empty_name_i) begin
      st    = '0;
      res_o = '{valid: 1'b1, enc_class: ENC_ASCII, utf8_valid: 1'b1};
    end else begin
      if (name_byte_i[7]) begin
        st.saw_high = 1'b1;
      end
      if (!cur_i.failed) begin
        if (cur_i.cont_left == 2'd0) begin
          if (name_byte_i[7]) begin
            if (name_byte_i[7:5] == LeadTwo) begin
              st.seq_extra = ExtraOne;
              st.cont_left = ExtraOne;
              st.cp_accum  = {16'd0, name_byte_i[4:0]};
            end else if (name_byte_i[7:4] == LeadThree) begin
              st.seq_extra = ExtraTwo;
              st.cont_left = ExtraTwo;
              st.cp_accum  = {17'd0, name_byte_i[3:0]};
            end else if (name_byte_i[7:3] == LeadFour) begin
              st.seq_extra = ExtraThree;
              st.cont_left = ExtraThree;
              st.cp_accum  = {18'd0, name_byte_i[2:0]};
            end else begin
              st.failed    = 1'b1;
              st.cont_left = 2'd0;
            end
          end
        end else if (name_byte_i[7:6] != ContTag) begin
          st.failed    = 1'b1;
          st.cont_left = 2'd0;
        end else begin
          st.cp_accum  = cp_new;
          st.cont_left = left_new;
          if ((left_new == 2'd0) && (overlong || bad_range)) begin
            st.failed = 1'b1;
          end
        end
      end

      if (last_byte_i) begin
        if (st.cont_left != 2'd0) begin
          st.failed = 1'b1;
        end
        res_o.valid      = 1'b1;
        res_o.utf8_valid = !st.failed;
        if (!st.saw_high) begin
          res_o.enc_class = ENC_ASCII;
        end else if (st.failed) begin
          res_o.enc_class = ENC_CP437;
        end else begin
          res_o.enc_class = ENC_UTF8;
        end
        st = '0;
      end
    end
    nxt_o = st;
  end

endmodule
